[hw/rtl/rmr_pkg.sv]
// ----------------------------------------------------------------------------
// Region map package
// Shared types and codes of the memory region map with reserve and find.
// ----------------------------------------------------------------------------
package rmr_pkg;

	localparam int MAX_ENTRIES_DEF = 128;
	localparam int PAGE_SHIFT      = 12;
	localparam logic [63:0] PAGE_BYTES = 64'(1) << PAGE_SHIFT;
	localparam logic [63:0] PAGE_MASK  = ~(PAGE_BYTES - 64'd1);

	localparam logic [2:0] OP_APPEND  = 3'd0;
	localparam logic [2:0] OP_RESERVE = 3'd1;
	localparam logic [2:0] OP_FIND    = 3'd2;
	localparam logic [2:0] OP_READ    = 3'd3;
	localparam logic [2:0] OP_CLEAR   = 3'd4;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_NOFIT = 2'd2;
	localparam logic [1:0] STAT_INDEX = 2'd3;

	localparam logic [31:0] KIND_RESERVED  = 32'd0;
	localparam logic [31:0] KIND_LDR_CODE  = 32'd1;
	localparam logic [31:0] KIND_LDR_DATA  = 32'd2;
	localparam logic [31:0] KIND_CONV      = 32'd7;
	localparam logic [31:0] KIND_LAST_WALK = 32'd7;

	typedef struct packed {
		logic [63:0] start;
		logic [51:0] pages;
		logic [31:0] kind;
		logic [63:0] attr;
	} rmr_entry_t;

endpackage

[hw/rtl/memory_region_map_reserve.sv]
// ----------------------------------------------------------------------------
// Memory region map with range reserve and highest-fit search
// Ordered region table in a synchronous memory, walked by a sequencer.
// ----------------------------------------------------------------------------
// Channel   Handshake            Payload
// command   start, busy          opcode .. entry_index
// result    done (one cycle)     status .. entry_total
//
// Append, clear and unknown opcodes finish straight from idle; read goes
// through S_READ. Find alternates a read and an evaluate state per entry.
// Reserve starts with an init step, then reads, latches and evaluates
// each entry walked; each insert checks room, moves entries up by a read
// and a write each and writes the insert, all paced by the one read port.
// Reset clears the entry count, the state and done; the table needs no clearing pass.
// Results are shown for one cycle on done and cannot be stalled.
// ----------------------------------------------------------------------------
module memory_region_map_reserve #(
	parameter int MAX_ENTRIES = rmr_pkg::MAX_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  opcode,
	input  logic [63:0] start_addr,
	input  logic [63:0] length_bytes,
	input  logic [63:0] limit_addr,
	input  logic [51:0] page_count,
	input  logic [31:0] region_kind,
	input  logic [63:0] attribute_bits,
	input  logic [6:0]  entry_index,
	output logic        done,
	output logic [1:0]  status,
	output logic [63:0] found_base,
	output logic [63:0] found_size,
	output logic [63:0] entry_start,
	output logic [51:0] entry_pages,
	output logic [31:0] entry_kind,
	output logic [63:0] entry_attribute,
	output logic [7:0]  entry_total
);
	import rmr_pkg::*;

	localparam int AW = $clog2(MAX_ENTRIES);
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int XW = CW + 8;

	typedef enum logic [3:0] {
		S_IDLE, S_READ, S_FIND_RD, S_FIND_EV, S_RS_INIT, S_RS_RD, S_RS_DE,
		S_RS_EV, S_INS_CHK, S_SH_RD, S_SH_WR, S_INS_WR, S_FIX_WR
	} state_t;

	typedef enum logic [1:0] {N_FRONT, N_TAIL, N_IN1, N_IN2} cont_t;

	state_t      state_q;
	cont_t       cont_q;
	logic [CW-1:0] count_q, i_q, k_q, pos_q;
	logic        done_q;
	logic [1:0]  status_q;
	logic [63:0] fbase_q, fsize_q, fb_q, fs_q;
	rmr_entry_t  rd_ent_q, ent_q, ins_q, ent2_q;
	logic [63:0] base_q, len_q, end_q, limit_q, de_q;

	logic        mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	rmr_entry_t  mem_wdata, rdata;

	logic [XW-1:0] idx_ext, cnt_ext;
	logic        full, idx_bad;
	logic [CW-1:0] k_dec, pos_inc, i_inc;

	logic [63:0] db, d_end_db, d_de_end, d_base_db, d_de_base;
	logic [31:0] kd;
	logic        hit, c_full, c_front, c_tail;
	rmr_entry_t  short_ent, zero_ent;

	logic [63:0] fl, fsum;
	logic        f_free;

	rmr_mem #(.DEPTH(MAX_ENTRIES), .AW(AW)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (rdata)
	);

	assign idx_ext = XW'(entry_index);
	assign cnt_ext = XW'(count_q);
	assign full    = (count_q == CW'(MAX_ENTRIES));
	assign idx_bad = (idx_ext >= cnt_ext);
	assign k_dec   = k_q - CW'(1);
	assign pos_inc = pos_q + CW'(1);
	assign i_inc   = i_q + CW'(1);

	assign db        = ent_q.start;
	assign kd        = ent_q.kind;
	assign d_end_db  = end_q - db;
	assign d_de_end  = de_q - end_q;
	assign d_base_db = base_q - db;
	assign d_de_base = de_q - base_q;
	assign hit       = (kd != KIND_RESERVED) && (kd <= KIND_LAST_WALK) &&
	                   !(end_q <= db || base_q >= de_q);
	assign c_front   = (base_q <= db);
	assign c_full    = c_front && (de_q <= end_q);
	assign c_tail    = (end_q >= de_q);
	assign short_ent = '{start: db, pages: d_base_db[63:PAGE_SHIFT], kind: kd,
	                     attr: ent_q.attr};
	assign zero_ent  = '{start: db, pages: ent_q.pages, kind: KIND_RESERVED,
	                     attr: ent_q.attr};

	assign fl     = {rdata.pages, {PAGE_SHIFT{1'b0}}};
	assign fsum   = rdata.start + fl;
	assign f_free = (rdata.kind == KIND_LDR_CODE) || (rdata.kind == KIND_LDR_DATA) ||
	                (rdata.kind == KIND_CONV);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = i_q[AW-1:0];
		mem_wdata = short_ent;
		mem_raddr = i_q[AW-1:0];
		case (state_q)
			S_IDLE: begin
				mem_raddr = idx_ext[AW-1:0];
				mem_waddr = count_q[AW-1:0];
				mem_wdata = '{start: start_addr, pages: page_count, kind: region_kind,
				              attr: attribute_bits};
				mem_we    = start && (opcode == OP_APPEND) && !full;
			end
			S_RS_EV: begin
				mem_we    = hit && !(c_front && !c_full);
				mem_wdata = c_full ? zero_ent : short_ent;
			end
			S_SH_RD: begin
				mem_raddr = k_dec[AW-1:0];
			end
			S_SH_WR: begin
				mem_we    = 1'b1;
				mem_waddr = k_q[AW-1:0];
				mem_wdata = rdata;
			end
			S_INS_WR: begin
				mem_we    = 1'b1;
				mem_waddr = pos_q[AW-1:0];
				mem_wdata = ins_q;
			end
			S_FIX_WR: begin
				mem_we    = 1'b1;
				mem_waddr = pos_inc[AW-1:0];
				mem_wdata = ent2_q;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						status_q <= STAT_OK;
						fbase_q  <= '0;
						fsize_q  <= '0;
						rd_ent_q <= '0;
						fb_q     <= '0;
						fs_q     <= '0;
						i_q      <= '0;
						case (opcode)
							OP_APPEND: begin
								done_q <= 1'b1;
								if (full) begin
									status_q <= STAT_FULL;
								end else begin
									count_q <= count_q + CW'(1);
								end
							end
							OP_RESERVE: begin
								base_q <= start_addr & PAGE_MASK;
								if ((length_bytes & ~PAGE_MASK) != 64'd0) begin
									len_q <= (length_bytes & PAGE_MASK) + PAGE_BYTES;
								end else begin
									len_q <= length_bytes;
								end
								if (length_bytes == 64'd0 || count_q == '0) begin
									done_q <= 1'b1;
								end else begin
									state_q <= S_RS_INIT;
								end
							end
							OP_FIND: begin
								len_q   <= length_bytes;
								limit_q <= limit_addr;
								state_q <= S_FIND_RD;
							end
							OP_READ: begin
								if (idx_bad) begin
									status_q <= STAT_INDEX;
									done_q   <= 1'b1;
								end else begin
									state_q <= S_READ;
								end
							end
							OP_CLEAR: begin
								count_q <= '0;
								done_q  <= 1'b1;
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				S_READ: begin
					rd_ent_q <= rdata;
					done_q   <= 1'b1;
					state_q  <= S_IDLE;
				end
				S_FIND_RD: begin
					if (i_q >= count_q) begin
						status_q <= (fs_q == '0) ? STAT_NOFIT : STAT_OK;
						fbase_q  <= (fs_q == '0) ? '0 : fb_q;
						fsize_q  <= fs_q;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_FIND_EV;
					end
				end
				S_FIND_EV: begin
					if (f_free && fsum > limit_q) begin
						status_q <= (fs_q == '0) ? STAT_NOFIT : STAT_OK;
						fbase_q  <= (fs_q == '0) ? '0 : fb_q;
						fsize_q  <= fs_q;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						if (f_free && len_q <= fl) begin
							fb_q <= rdata.start;
							fs_q <= fl;
						end
						i_q     <= i_inc;
						state_q <= S_FIND_RD;
					end
				end
				S_RS_INIT: begin
					end_q   <= base_q + len_q;
					state_q <= S_RS_RD;
				end
				S_RS_RD: begin
					if (i_q >= count_q) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_RS_DE;
					end
				end
				S_RS_DE: begin
					ent_q   <= rdata;
					de_q    <= rdata.start + {rdata.pages, {PAGE_SHIFT{1'b0}}};
					state_q <= S_RS_EV;
				end
				S_RS_EV: begin
					if (!hit || c_full) begin
						i_q     <= i_inc;
						state_q <= S_RS_RD;
					end else if (c_front) begin
						ins_q   <= '{start: db, pages: d_end_db[63:PAGE_SHIFT],
						             kind: KIND_RESERVED, attr: ent_q.attr};
						ent2_q  <= '{start: end_q, pages: d_de_end[63:PAGE_SHIFT],
						             kind: kd, attr: ent_q.attr};
						pos_q   <= i_q;
						cont_q  <= N_FRONT;
						state_q <= S_INS_CHK;
					end else if (c_tail) begin
						ins_q   <= '{start: base_q, pages: d_de_base[63:PAGE_SHIFT],
						             kind: KIND_RESERVED, attr: ent_q.attr};
						pos_q   <= i_inc;
						cont_q  <= N_TAIL;
						state_q <= S_INS_CHK;
					end else begin
						ins_q   <= '{start: base_q, pages: len_q[63:PAGE_SHIFT],
						             kind: KIND_RESERVED, attr: ent_q.attr};
						ent2_q  <= '{start: end_q, pages: d_de_end[63:PAGE_SHIFT],
						             kind: kd, attr: ent_q.attr};
						pos_q   <= i_inc;
						cont_q  <= N_IN1;
						state_q <= S_INS_CHK;
					end
				end
				S_INS_CHK: begin
					k_q <= count_q;
					if (full) begin
						status_q <= STAT_FULL;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else if (count_q > pos_q) begin
						state_q <= S_SH_RD;
					end else begin
						state_q <= S_INS_WR;
					end
				end
				S_SH_RD: begin
					state_q <= S_SH_WR;
				end
				S_SH_WR: begin
					k_q     <= k_dec;
					state_q <= (k_dec > pos_q) ? S_SH_RD : S_INS_WR;
				end
				S_INS_WR: begin
					count_q <= count_q + CW'(1);
					case (cont_q)
						N_FRONT: begin
							state_q <= S_FIX_WR;
						end
						N_TAIL: begin
							i_q     <= pos_inc;
							state_q <= S_RS_RD;
						end
						N_IN1: begin
							ins_q   <= ent2_q;
							pos_q   <= pos_inc;
							cont_q  <= N_IN2;
							state_q <= S_INS_CHK;
						end
						default: begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
					endcase
				end
				S_FIX_WR: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy            = (state_q != S_IDLE);
	assign done            = done_q;
	assign status          = status_q;
	assign found_base      = fbase_q;
	assign found_size      = fsize_q;
	assign entry_start     = rd_ent_q.start;
	assign entry_pages     = rd_ent_q.pages;
	assign entry_kind      = rd_ent_q.kind;
	assign entry_attribute = rd_ent_q.attr;
	assign entry_total     = cnt_ext[7:0];

endmodule

[hw/rtl/rmr_mem.sv]
// ----------------------------------------------------------------------------
// Region table memory
// One write port and one registered read port.
// ----------------------------------------------------------------------------
module rmr_mem #(
	parameter int DEPTH = rmr_pkg::MAX_ENTRIES_DEF,
	parameter int AW    = $clog2(rmr_pkg::MAX_ENTRIES_DEF)
) (
	input  logic                clk,
	input  logic                we,
	input  logic [AW-1:0]       waddr,
	input  rmr_pkg::rmr_entry_t wdata,
	input  logic [AW-1:0]       raddr,
	output rmr_pkg::rmr_entry_t rdata
);
	import rmr_pkg::*;

	rmr_entry_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[hw/rtl/rmr_checker.sv]
// ----------------------------------------------------------------------------
// Region map port checker
// Watches the command and result ports of the region map over time.
// ----------------------------------------------------------------------------
module rmr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [1:0]  status,
	input logic [63:0] found_base,
	input logic [63:0] found_size,
	input logic [63:0] entry_start,
	input logic [31:0] entry_kind
);
	import rmr_pkg::*;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result beat while busy");

	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start)) else $error("busy without a command beat");

	a_busy_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done) else $error("operation ended without a result beat");

	a_nofit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == STAT_NOFIT) |-> (found_base == '0 && found_size == '0))
		else $error("no-fit result carries a region");

	a_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == STAT_INDEX) |-> (entry_start == '0 && entry_kind == '0))
		else $error("bad index result carries an entry");

endmodule

bind memory_region_map_reserve rmr_checker u_rmr_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.status     (status),
	.found_base (found_base),
	.found_size (found_size),
	.entry_start(entry_start),
	.entry_kind (entry_kind)
);
